### rtl/jcc_pkg.sv
// ----------------------------------------------------------------------------
// jcc_pkg: shared types and tables for the japanese character classifier
// class codes, match vector and result types, constant code point sets
// ----------------------------------------------------------------------------
package jcc_pkg;

    // field widths
    localparam int CP_W  = 21;
    localparam int CLS_W = 5;

    typedef logic [CP_W-1:0]  cp_t;
    typedef logic [CLS_W-1:0] cls_t;
    typedef logic [15:0]      bmp_t;

    // primary class codes
    localparam cls_t CLS_SPACE        = 5'd0;
    localparam cls_t CLS_IDEO_PUNC    = 5'd1;
    localparam cls_t CLS_SYMBOL       = 5'd2;
    localparam cls_t CLS_HIRAGANA     = 5'd3;
    localparam cls_t CLS_KATAKANA     = 5'd4;
    localparam cls_t CLS_FULL_KANA    = 5'd5;
    localparam cls_t CLS_HANKAKU      = 5'd6;
    localparam cls_t CLS_MIDDLE_DOT   = 5'd7;
    localparam cls_t CLS_COMMA        = 5'd8;
    localparam cls_t CLS_SLASH        = 5'd9;
    localparam cls_t CLS_COLON        = 5'd10;
    localparam cls_t CLS_PERIOD       = 5'd11;
    localparam cls_t CLS_FIGURE       = 5'd12;
    localparam cls_t CLS_KANJI_FIGURE = 5'd13;
    localparam cls_t CLS_FIGURE_EXC   = 5'd14;
    localparam cls_t CLS_ALPH         = 5'd15;
    localparam cls_t CLS_KANJI        = 5'd16;
    localparam cls_t CLS_BRACKET      = 5'd17;

    // one bit per test, before priority is applied
    typedef struct packed {
        logic space;
        logic ideo_punc;
        logic era;
        logic hiragana;
        logic katakana;
        logic tiny_kana;
        logic full_choon;
        logic half_choon;
        logic hankaku;
        logic mid_dot;
        logic comma;
        logic slash;
        logic colon;
        logic period;
        logic figure;
        logic kanji_fig;
        logic place_digit;
        logic figure_exc;
        logic alph;
        logic kanji;
        logic bracket;
    } match_t;

    // one classified transaction
    typedef struct packed {
        cls_t primary_class;
        logic era_mark;
        logic tiny_kana;
        logic choon_mark;
        logic kanji_also;
        logic place_value;
    } result_t;

    // constant sets, all inside the basic multilingual plane
    localparam int SPACE_N   = 8;
    localparam int SMALL_N   = 24;
    localparam int KFIG_N    = 12;
    localparam int PLACE_N   = 6;
    localparam int BRACKET_N = 120;

    localparam bmp_t SPACE_ROM [SPACE_N] = '{
        16'h0020, 16'h3000, 16'h00A0, 16'h1680, 16'h180E, 16'h202F, 16'h205F, 16'hFEFF};

    localparam bmp_t SMALL_ROM [SMALL_N] = '{
        16'h3041, 16'h3043, 16'h3045, 16'h3047, 16'h3049, 16'h3063, 16'h3083, 16'h3085,
        16'h3087, 16'h308E, 16'h3095, 16'h3096, 16'h30A1, 16'h30A3, 16'h30A5, 16'h30A7,
        16'h30A9, 16'h30C3, 16'h30E3, 16'h30E5, 16'h30E7, 16'h30EE, 16'h30F5, 16'h30F6};

    localparam bmp_t KFIG_ROM [KFIG_N] = '{
        16'h25CB, 16'h3007, 16'h96F6, 16'h4E00, 16'h4E8C, 16'h4E09,
        16'h56DB, 16'h4E94, 16'h516D, 16'h4E03, 16'h516B, 16'h4E5D};

    localparam bmp_t PLACE_ROM [PLACE_N] = '{
        16'h5341, 16'h767E, 16'h5343, 16'h4E07, 16'h5104, 16'h5146};

    localparam bmp_t BRACKET_ROM [BRACKET_N] = '{
        16'h0028, 16'h0029, 16'h005B, 16'h005D, 16'h007B, 16'h007D, 16'h0F3A, 16'h0F3B,
        16'h0F3C, 16'h0F3D, 16'h169B, 16'h169C, 16'h2045, 16'h2046, 16'h207D, 16'h207E,
        16'h208D, 16'h208E, 16'h2308, 16'h2309, 16'h230A, 16'h230B, 16'h2329, 16'h232A,
        16'h2768, 16'h2769, 16'h276A, 16'h276B, 16'h276C, 16'h276D, 16'h276E, 16'h276F,
        16'h2770, 16'h2771, 16'h2772, 16'h2773, 16'h2774, 16'h2775, 16'h27C5, 16'h27C6,
        16'h27E6, 16'h27E7, 16'h27E8, 16'h27E9, 16'h27EA, 16'h27EB, 16'h27EC, 16'h27ED,
        16'h27EE, 16'h27EF, 16'h2983, 16'h2984, 16'h2985, 16'h2986, 16'h2987, 16'h2988,
        16'h2989, 16'h298A, 16'h298B, 16'h298C, 16'h298D, 16'h2990, 16'h298F, 16'h298E,
        16'h2991, 16'h2992, 16'h2993, 16'h2994, 16'h2995, 16'h2996, 16'h2997, 16'h2998,
        16'h29D8, 16'h29D9, 16'h29DA, 16'h29DB, 16'h29FC, 16'h29FD, 16'h2E22, 16'h2E23,
        16'h2E24, 16'h2E25, 16'h2E26, 16'h2E27, 16'h2E28, 16'h2E29, 16'h3008, 16'h3009,
        16'h300A, 16'h300B, 16'h300C, 16'h300D, 16'h300E, 16'h300F, 16'h3010, 16'h3011,
        16'h3014, 16'h3015, 16'h3016, 16'h3017, 16'h3018, 16'h3019, 16'h301A, 16'h301B,
        16'hFE59, 16'hFE5A, 16'hFE5B, 16'hFE5C, 16'hFE5D, 16'hFE5E, 16'hFF08, 16'hFF09,
        16'hFF3B, 16'hFF3D, 16'hFF5B, 16'hFF5D, 16'hFF5F, 16'hFF60, 16'hFF62, 16'hFF63};

    // set membership, each entry compared in parallel
    function automatic logic in_space(input cp_t c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < SPACE_N; i++)
        begin
            if (c == {5'd0, SPACE_ROM[i]})
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic in_small(input cp_t c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < SMALL_N; i++)
        begin
            if (c == {5'd0, SMALL_ROM[i]})
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic in_kfig(input cp_t c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < KFIG_N; i++)
        begin
            if (c == {5'd0, KFIG_ROM[i]})
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic in_place(input cp_t c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < PLACE_N; i++)
        begin
            if (c == {5'd0, PLACE_ROM[i]})
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic in_bracket(input cp_t c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < BRACKET_N; i++)
        begin
            if (c == {5'd0, BRACKET_ROM[i]})
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

### rtl/jcc_match.sv
// ----------------------------------------------------------------------------
// jcc_match: per-test comparators
// evaluates every range and set test on one code point, no priority yet
// ----------------------------------------------------------------------------
module jcc_match
(
    input  jcc_pkg::cp_t    cp,
    output jcc_pkg::match_t hits
);

    // range and equality tests
    always_comb
    begin
        hits.space       = jcc_pkg::in_space(cp) || (cp >= 21'h2000 && cp <= 21'h200B);
        hits.ideo_punc   = (cp > 21'h3000) && (cp < 21'h3003);
        hits.era         = (cp >= 21'h337B) && (cp <= 21'h337E);
        hits.hiragana    = (cp >= 21'h3040) && (cp <= 21'h309F);
        hits.katakana    = (cp >= 21'h30A0 && cp <= 21'h30FA) ||
                           (cp >= 21'h30FD && cp <= 21'h30FF);
        hits.tiny_kana   = jcc_pkg::in_small(cp);
        hits.full_choon  = (cp == 21'h30FC) || (cp == 21'h301C) ||
                           (cp == 21'hFF5E) || (cp == 21'h223C);
        hits.half_choon  = (cp == 21'hFF70);
        hits.hankaku     = (cp >= 21'hFF66) && (cp <= 21'hFF9F);
        hits.mid_dot     = (cp == 21'h00B7) || (cp == 21'h30FB);
        hits.comma       = (cp == 21'h002C) || (cp == 21'hFF0C);
        hits.slash       = (cp == 21'h002F) || (cp == 21'hFF0F);
        hits.colon       = (cp == 21'h003A) || (cp == 21'hFF1A);
        hits.period      = (cp == 21'hFF0E);
        hits.figure      = (cp >= 21'h0030 && cp <= 21'h0039) ||
                           (cp >= 21'hFF10 && cp <= 21'hFF19);
        hits.kanji_fig   = jcc_pkg::in_kfig(cp);
        hits.place_digit = jcc_pkg::in_place(cp);
        hits.figure_exc  = (cp == 21'h6570) || (cp == 21'h4F55) || (cp == 21'h5E7E);
        hits.alph        = (cp >= 21'h0041 && cp <= 21'h005A) ||
                           (cp >= 21'h0061 && cp <= 21'h007A) ||
                           (cp >= 21'h00C0 && cp <= 21'h00FF) ||
                           (cp >= 21'hFF21 && cp <= 21'hFF3A) ||
                           (cp >= 21'hFF41 && cp <= 21'hFF5A);
        hits.kanji       = (cp > 21'h4DFF && cp < 21'hA000) ||
                           (cp == 21'h3005) || (cp == 21'h3007);
        hits.bracket     = jcc_pkg::in_bracket(cp);
    end

endmodule

### rtl/jcc_resolve.sv
// ----------------------------------------------------------------------------
// jcc_resolve: priority resolution
// picks the first matching test and builds the class and modifier flags
// ----------------------------------------------------------------------------
module jcc_resolve
(
    input  jcc_pkg::match_t  hits,
    output jcc_pkg::result_t res
);

    // first match wins, flags follow the winning test only
    always_comb
    begin
        res = '0;
        res.primary_class = jcc_pkg::CLS_SYMBOL;
        if (hits.space)
        begin
            res.primary_class = jcc_pkg::CLS_SPACE;
        end
        else if (hits.ideo_punc)
        begin
            res.primary_class = jcc_pkg::CLS_IDEO_PUNC;
        end
        else if (hits.era)
        begin
            res.primary_class = jcc_pkg::CLS_SYMBOL;
            res.era_mark      = 1'b1;
        end
        else if (hits.hiragana)
        begin
            res.primary_class = jcc_pkg::CLS_HIRAGANA;
            res.tiny_kana     = hits.tiny_kana;
        end
        else if (hits.katakana)
        begin
            res.primary_class = jcc_pkg::CLS_KATAKANA;
            res.tiny_kana     = hits.tiny_kana;
        end
        else if (hits.full_choon)
        begin
            res.primary_class = jcc_pkg::CLS_FULL_KANA;
            res.choon_mark    = 1'b1;
        end
        else if (hits.half_choon)
        begin
            res.primary_class = jcc_pkg::CLS_HANKAKU;
            res.choon_mark    = 1'b1;
        end
        else if (hits.hankaku)
        begin
            res.primary_class = jcc_pkg::CLS_HANKAKU;
        end
        else if (hits.mid_dot)
        begin
            res.primary_class = jcc_pkg::CLS_MIDDLE_DOT;
        end
        else if (hits.comma)
        begin
            res.primary_class = jcc_pkg::CLS_COMMA;
        end
        else if (hits.slash)
        begin
            res.primary_class = jcc_pkg::CLS_SLASH;
        end
        else if (hits.colon)
        begin
            res.primary_class = jcc_pkg::CLS_COLON;
        end
        else if (hits.period)
        begin
            res.primary_class = jcc_pkg::CLS_PERIOD;
        end
        else if (hits.figure)
        begin
            res.primary_class = jcc_pkg::CLS_FIGURE;
        end
        else if (hits.kanji_fig)
        begin
            res.primary_class = jcc_pkg::CLS_KANJI_FIGURE;
            res.kanji_also    = 1'b1;
        end
        else if (hits.place_digit)
        begin
            res.primary_class = jcc_pkg::CLS_KANJI_FIGURE;
            res.place_value   = 1'b1;
        end
        else if (hits.figure_exc)
        begin
            res.primary_class = jcc_pkg::CLS_FIGURE_EXC;
            res.kanji_also    = 1'b1;
        end
        else if (hits.alph)
        begin
            res.primary_class = jcc_pkg::CLS_ALPH;
        end
        else if (hits.kanji)
        begin
            res.primary_class = jcc_pkg::CLS_KANJI;
        end
        else if (hits.bracket)
        begin
            res.primary_class = jcc_pkg::CLS_BRACKET;
        end
    end

endmodule

### rtl/japanese_char_classifier_top.sv
// ----------------------------------------------------------------------------
// japanese_char_classifier_top: code point classifier for japanese text
// throughput: one transaction per cycle while out_stall is low, three-stage pipeline
// stages: input register, comparator register, priority/output register
// stalls: each stage holds its data while blocked, bubbles are squeezed out
// reset: rst_n asynchronous active low clears all stage valid bits
// ----------------------------------------------------------------------------
module japanese_char_classifier_top
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  jcc_pkg::cp_t            code_point,
    output logic                    out_valid,
    input  logic                    out_stall,
    output jcc_pkg::cls_t           primary_class,
    output logic                    era_mark,
    output logic                    tiny_kana,
    output logic                    choon_mark,
    output logic                    kanji_also,
    output logic                    place_value
);

    logic             s1_valid_reg;
    logic             s2_valid_reg;
    logic             s3_valid_reg;
    jcc_pkg::cp_t     s1_cp_reg;
    jcc_pkg::match_t  s2_hits_reg;
    jcc_pkg::match_t  s2_hits_next;
    jcc_pkg::result_t s3_res_reg;
    jcc_pkg::result_t s3_res_next;
    logic             s1_adv;
    logic             s2_adv;
    logic             s3_adv;

    // per-stage advance: a stage moves when empty or when its successor moves
    assign s3_adv   = !s3_valid_reg || !out_stall;
    assign s2_adv   = !s2_valid_reg || s3_adv;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_stall = !s1_adv;

    // comparators between stage 1 and stage 2
    jcc_match u_match
    (
        .cp   (s1_cp_reg),
        .hits (s2_hits_next)
    );

    // priority between stage 2 and stage 3
    jcc_resolve u_resolve
    (
        .hits (s2_hits_reg),
        .res  (s3_res_next)
    );

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_adv)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_cp_reg <= code_point;
        end
        if (s2_adv)
        begin
            s2_hits_reg <= s2_hits_next;
        end
        if (s3_adv)
        begin
            s3_res_reg <= s3_res_next;
        end
    end

    // outputs
    assign out_valid     = s3_valid_reg;
    assign primary_class = s3_res_reg.primary_class;
    assign era_mark      = s3_res_reg.era_mark;
    assign tiny_kana     = s3_res_reg.tiny_kana;
    assign choon_mark    = s3_res_reg.choon_mark;
    assign kanji_also    = s3_res_reg.kanji_also;
    assign place_value   = s3_res_reg.place_value;

    // input stall only when every stage is full and the output is blocked
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && out_stall))
        else $error("input stalled while the pipeline has room");

    // era flag only on symbol class
    a_era_cls: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && era_mark) |-> (primary_class == jcc_pkg::CLS_SYMBOL))
        else $error("era flag on a non-symbol class");

    // small kana flag only on kana classes
    a_tiny_cls: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && tiny_kana) |->
        (primary_class == jcc_pkg::CLS_HIRAGANA || primary_class == jcc_pkg::CLS_KATAKANA))
        else $error("small kana flag on a non-kana class");

    // prolonged sound flag only on kana family or half-width classes
    a_choon_cls: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && choon_mark) |->
        (primary_class == jcc_pkg::CLS_FULL_KANA || primary_class == jcc_pkg::CLS_HANKAKU))
        else $error("prolonged sound flag on an unexpected class");

endmodule

### tb/tb_japanese_char_classifier_top.sv
// ----------------------------------------------------------------------------
// tb_japanese_char_classifier_top: self-checking bench for the code point classifier
// drives directed and random code points through the valid/stall input,
// predicts the class and flags of each transaction, and compares them in order
// with what leaves the output under random idling and back-pressure
// ----------------------------------------------------------------------------
module tb_japanese_char_classifier_top;

    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 850;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 17;

    // expected classes of accepted code points, checked in arrival order
    class char_class_checker;
        jcc_pkg::result_t expected_classes[$];
        int               fail_count;

        function new();
            fail_count = 0;
        endfunction

        // ordered tests, the first match decides the class
        function jcc_pkg::result_t classify(jcc_pkg::cp_t c);
            jcc_pkg::result_t r;
            r = '0;
            r.primary_class = jcc_pkg::CLS_SYMBOL;
            if (c inside {'h0020, 'h3000, 'h00A0, 'h1680, 'h180E, 'h202F, 'h205F, 'hFEFF,
                          ['h2000:'h200B]})
            begin
                r.primary_class = jcc_pkg::CLS_SPACE;
            end
            else if (c inside {'h3001, 'h3002})
            begin
                r.primary_class = jcc_pkg::CLS_IDEO_PUNC;
            end
            else if (c inside {['h337B:'h337E]})
            begin
                r.era_mark = 1'b1;
            end
            else if (c inside {['h3040:'h309F]})
            begin
                r.primary_class = jcc_pkg::CLS_HIRAGANA;
                r.tiny_kana = is_tiny_kana(c);
            end
            else if (c inside {['h30A0:'h30FA], ['h30FD:'h30FF]})
            begin
                r.primary_class = jcc_pkg::CLS_KATAKANA;
                r.tiny_kana = is_tiny_kana(c);
            end
            else if (c inside {'h30FC, 'h301C, 'hFF5E, 'h223C})
            begin
                r.primary_class = jcc_pkg::CLS_FULL_KANA;
                r.choon_mark = 1'b1;
            end
            else if (c == 'hFF70)
            begin
                r.primary_class = jcc_pkg::CLS_HANKAKU;
                r.choon_mark = 1'b1;
            end
            else if (c inside {['hFF66:'hFF9F]})
            begin
                r.primary_class = jcc_pkg::CLS_HANKAKU;
            end
            else if (c inside {'h00B7, 'h30FB})
            begin
                r.primary_class = jcc_pkg::CLS_MIDDLE_DOT;
            end
            else if (c inside {'h002C, 'hFF0C})
            begin
                r.primary_class = jcc_pkg::CLS_COMMA;
            end
            else if (c inside {'h002F, 'hFF0F})
            begin
                r.primary_class = jcc_pkg::CLS_SLASH;
            end
            else if (c inside {'h003A, 'hFF1A})
            begin
                r.primary_class = jcc_pkg::CLS_COLON;
            end
            else if (c == 'hFF0E)
            begin
                r.primary_class = jcc_pkg::CLS_PERIOD;
            end
            else if (c inside {['h0030:'h0039], ['hFF10:'hFF19]})
            begin
                r.primary_class = jcc_pkg::CLS_FIGURE;
            end
            else if (c inside {'h25CB, 'h3007, 'h96F6, 'h4E00, 'h4E8C, 'h4E09,
                               'h56DB, 'h4E94, 'h516D, 'h4E03, 'h516B, 'h4E5D})
            begin
                r.primary_class = jcc_pkg::CLS_KANJI_FIGURE;
                r.kanji_also = 1'b1;
            end
            else if (c inside {'h5341, 'h767E, 'h5343, 'h4E07, 'h5104, 'h5146})
            begin
                r.primary_class = jcc_pkg::CLS_KANJI_FIGURE;
                r.place_value = 1'b1;
            end
            else if (c inside {'h6570, 'h4F55, 'h5E7E})
            begin
                r.primary_class = jcc_pkg::CLS_FIGURE_EXC;
                r.kanji_also = 1'b1;
            end
            else if (c inside {['h0041:'h005A], ['h0061:'h007A], ['h00C0:'h00FF],
                               ['hFF21:'hFF3A], ['hFF41:'hFF5A]})
            begin
                r.primary_class = jcc_pkg::CLS_ALPH;
            end
            else if (c inside {['h4E00:'h9FFF], 'h3005, 'h3007})
            begin
                r.primary_class = jcc_pkg::CLS_KANJI;
            end
            else if (c inside {'h0028, 'h0029, 'h005B, 'h005D, 'h007B, 'h007D,
                               ['h0F3A:'h0F3D], 'h169B, 'h169C, 'h2045, 'h2046,
                               'h207D, 'h207E, 'h208D, 'h208E, ['h2308:'h230B],
                               'h2329, 'h232A, ['h2768:'h2775], 'h27C5, 'h27C6,
                               ['h27E6:'h27EF], ['h2983:'h2998], ['h29D8:'h29DB],
                               'h29FC, 'h29FD, ['h2E22:'h2E29], ['h3008:'h3011],
                               ['h3014:'h301B], ['hFE59:'hFE5E], 'hFF08, 'hFF09,
                               'hFF3B, 'hFF3D, 'hFF5B, 'hFF5D, 'hFF5F, 'hFF60,
                               'hFF62, 'hFF63})
            begin
                r.primary_class = jcc_pkg::CLS_BRACKET;
            end
            return r;
        endfunction

        function logic is_tiny_kana(jcc_pkg::cp_t c);
            return c inside {'h3041, 'h3043, 'h3045, 'h3047, 'h3049, 'h3063, 'h3083, 'h3085,
                             'h3087, 'h308E, 'h3095, 'h3096, 'h30A1, 'h30A3, 'h30A5, 'h30A7,
                             'h30A9, 'h30C3, 'h30E3, 'h30E5, 'h30E7, 'h30EE, 'h30F5, 'h30F6};
        endfunction

        function void note_code_point(jcc_pkg::cp_t c);
            expected_classes.push_back(classify(c));
        endfunction

        function void check_class(jcc_pkg::result_t got);
            jcc_pkg::result_t want;
            if (expected_classes.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("unexpected result: class %0d flags %b%b%b%b%b",
                             got.primary_class, got.era_mark, got.tiny_kana,
                             got.choon_mark, got.kanji_also, got.place_value);
                end
                return;
            end
            want = expected_classes.pop_front();
            if (got.primary_class !== want.primary_class || got.era_mark !== want.era_mark ||
                got.tiny_kana !== want.tiny_kana || got.choon_mark !== want.choon_mark ||
                got.kanji_also !== want.kanji_also || got.place_value !== want.place_value)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("mismatch: expected class %0d flags %b%b%b%b%b",
                             want.primary_class, want.era_mark, want.tiny_kana,
                             want.choon_mark, want.kanji_also, want.place_value);
                    $display("          actual   class %0d flags %b%b%b%b%b",
                             got.primary_class, got.era_mark, got.tiny_kana,
                             got.choon_mark, got.kanji_also, got.place_value);
                end
            end
        endfunction
    endclass

    logic          clk        = 1'b0;
    logic          rst_n      = 1'b0;
    logic          in_valid   = 1'b0;
    logic          in_stall;
    jcc_pkg::cp_t  code_point = '0;
    logic          out_valid;
    logic          out_stall  = 1'b0;
    jcc_pkg::cls_t primary_class;
    logic          era_mark;
    logic          tiny_kana;
    logic          choon_mark;
    logic          kanji_also;
    logic          place_value;

    char_class_checker board;
    jcc_pkg::cp_t  notable[$];
    bit            calm = 1'b0;
    int            cycles = 0;

    japanese_char_classifier_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .code_point    (code_point),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .primary_class (primary_class),
        .era_mark      (era_mark),
        .tiny_kana     (tiny_kana),
        .choon_mark    (choon_mark),
        .kanji_also    (kanji_also),
        .place_value   (place_value)
    );

    // clock
    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: check each accepted transaction, stall at random
    always @(posedge clk)
    begin
        jcc_pkg::result_t got;
        if (out_valid && !out_stall)
        begin
            got.primary_class = primary_class;
            got.era_mark      = era_mark;
            got.tiny_kana     = tiny_kana;
            got.choon_mark    = choon_mark;
            got.kanji_also    = kanji_also;
            got.place_value   = place_value;
            board.check_class(got);
        end
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // edges of a range, one step outside and inside
    task automatic add_span(input int unsigned lo, input int unsigned hi);
        notable.push_back(jcc_pkg::cp_t'(lo - 1));
        notable.push_back(jcc_pkg::cp_t'(lo));
        notable.push_back(jcc_pkg::cp_t'(hi));
        notable.push_back(jcc_pkg::cp_t'(hi + 1));
    endtask

    // mix of set members, range edges, japanese blocks and the full field
    function automatic jcc_pkg::cp_t pick_code_point();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 40)
        begin
            return notable[$urandom_range(notable.size() - 1)];
        end
        else if (sel < 55)
        begin
            return jcc_pkg::cp_t'($urandom_range('h3000, 'h30FF));
        end
        else if (sel < 65)
        begin
            return jcc_pkg::cp_t'($urandom_range('hFF00, 'hFFFF));
        end
        else if (sel < 72)
        begin
            return jcc_pkg::cp_t'($urandom_range('h4DF0, 'hA010));
        end
        else if (sel < 80)
        begin
            return jcc_pkg::cp_t'($urandom_range(0, 'hFF));
        end
        else if (sel < 90)
        begin
            return jcc_pkg::cp_t'($urandom_range(0, 'hFFFF));
        end
        return jcc_pkg::cp_t'($urandom());
    endfunction

    // one transaction on the input, with random idle cycles ahead of it
    task automatic send_code_point(input jcc_pkg::cp_t cp);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid   <= 1'b0;
            code_point <= jcc_pkg::cp_t'($urandom());
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        code_point <= cp;
        do @(posedge clk); while (in_stall);
        board.note_code_point(cp);
    endtask

    task automatic wait_drained();
        while (board.expected_classes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int unsigned directed[$];
        int unsigned singles[$];
        directed = '{'h000000, 'h1FFFFF, 'h10FFFF, 'h110000, 'hD800, 'h3007,
                     'h0020, 'h3001, 'h337B, 'h3041, 'h3042, 'h30A1, 'h30FC,
                     'hFF70, 'hFF66, 'h00B7, 'h002C, 'h002F, 'h003A, 'hFF0E,
                     'h0035, 'h4E00, 'h5341, 'h6570, 'h0041, 'h4E01, 'h0028};
        singles = '{'h0020, 'h3000, 'h00A0, 'h1680, 'h180E, 'h202F, 'h205F, 'hFEFF,
                    'h3041, 'h3043, 'h3045, 'h3047, 'h3049, 'h3063, 'h3083, 'h3085,
                    'h3087, 'h308E, 'h3095, 'h3096, 'h30A1, 'h30A3, 'h30A5, 'h30A7,
                    'h30A9, 'h30C3, 'h30E3, 'h30E5, 'h30E7, 'h30EE, 'h30F5, 'h30F6,
                    'h30FC, 'h301C, 'hFF5E, 'h223C, 'hFF70, 'h00B7, 'h30FB,
                    'h002C, 'hFF0C, 'h002F, 'hFF0F, 'h003A, 'hFF1A, 'hFF0E,
                    'h25CB, 'h3007, 'h96F6, 'h4E00, 'h4E8C, 'h4E09,
                    'h56DB, 'h4E94, 'h516D, 'h4E03, 'h516B, 'h4E5D,
                    'h5341, 'h767E, 'h5343, 'h4E07, 'h5104, 'h5146,
                    'h6570, 'h4F55, 'h5E7E, 'h3005,
                    'h0028, 'h0029, 'h005B, 'h005D, 'h007B, 'h007D, 'h0F3A, 'h169B,
                    'h2045, 'h207D, 'h208D, 'h2308, 'h2329, 'h27C5, 'h27E6, 'h29D8,
                    'h29FC, 'h2E22, 'hFE59, 'hFF08, 'hFF3B, 'hFF3D, 'hFF5B, 'hFF5D,
                    'hFF5F, 'hFF62, 'hFF63};
        board = new();

        // pool of interesting code points for the random part
        foreach (singles[i])
        begin
            add_span(singles[i], singles[i]);
        end
        add_span('h2000, 'h200B);
        add_span('h3001, 'h3002);
        add_span('h337B, 'h337E);
        add_span('h3040, 'h309F);
        add_span('h30A0, 'h30FA);
        add_span('h30FD, 'h30FF);
        add_span('hFF66, 'hFF9F);
        add_span('h0030, 'h0039);
        add_span('hFF10, 'hFF19);
        add_span('h0041, 'h005A);
        add_span('h0061, 'h007A);
        add_span('h00C0, 'h00FF);
        add_span('hFF21, 'hFF3A);
        add_span('hFF41, 'hFF5A);
        add_span('h4E00, 'h9FFF);
        add_span('h2768, 'h2775);
        add_span('h2983, 'h2998);
        add_span('h3008, 'h3011);
        add_span('h3014, 'h301B);
        add_span('hD800, 'hDFFF);
        add_span('h10FFFF, 'h10FFFF);

        // reset
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed transactions
        foreach (directed[i])
        begin
            send_code_point(jcc_pkg::cp_t'(directed[i]));
        end

        // let the pipeline drain completely before the random part
        in_valid <= 1'b0;
        wait_drained();

        // random transactions, with a stretch free of idling
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= 300 && i < 450);
            send_code_point(pick_code_point());
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // wait for the last results, then a few spare cycles
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.expected_classes.size() != 0)
        begin
            board.fail_count++;
        end
        if (board.fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### japanese_char_classifier_top.f
rtl/jcc_pkg.sv
rtl/jcc_match.sv
rtl/jcc_resolve.sv
rtl/japanese_char_classifier_top.sv
tb/tb_japanese_char_classifier_top.sv
